### rtl/core/rse_pkg.sv
// Shared types, constants and GF(256) helper functions for the Reed-Solomon parity encoder.
`default_nettype none

package rse_pkg;

    // Default number of parity bytes the remainder register is built for.
    localparam int PKG_MAX_DEGREE = 30;
    // Largest remainder depth that the coefficient rows can describe.
    localparam int MAX_DEGREE_LIMIT = 64;
    // Width of the degree register.
    localparam int DEG_WIDTH = 5;
    localparam logic [DEG_WIDTH-1:0] DEGREE_RESET = 5'd10;

    // Index of the degree register on the configuration port.
    localparam int REG_ECC_DEGREE = 0;

    // Field polynomial x^8 + x^4 + x^3 + x^2 + 1, and the generator root.
    localparam logic [8:0] GF_POLY = 9'h11D;
    localparam logic [7:0] GF_ROOT = 8'h02;

    typedef logic [7:0] t_byte;
    typedef t_byte [MAX_DEGREE_LIMIT-1:0] t_coef_row;

    // Control from the top level into the remainder datapath.
    typedef struct packed {
        logic                 accept;
        logic                 last;
        logic                 clear;
        logic [DEG_WIDTH-1:0] degree;
    } t_div_ctrl;

    // GF(256) product, shift-and-reduce with the most significant bit of b first.
    function automatic t_byte gf_mul(t_byte a, t_byte b);
        t_byte acc;
        acc = 8'h00;
        for (int bit_i = 7; bit_i >= 0; bit_i--) begin
            acc = {acc[6:0], 1'b0} ^ (acc[7] ? GF_POLY[7:0] : 8'h00);
            acc = acc ^ (b[bit_i] ? a : 8'h00);
        end
        return acc;
    endfunction

    // Degree actually used: zero counts as one, and large values saturate.
    function automatic int eff_degree(logic [DEG_WIDTH-1:0] deg, int max_deg);
        int d;
        d = int'(deg);
        if (d < 1) begin
            d = 1;
        end
        if (d > max_deg) begin
            d = max_deg;
        end
        return d;
    endfunction

    // Generator polynomial coefficients for degree d, leading (monic) term dropped.
    // Only evaluated at elaboration time.
    function automatic t_coef_row gen_row(int d);
        t_coef_row coef;
        t_byte     root;
        coef        = '0;
        root        = 8'h01;
        coef[d - 1] = 8'h01;
        for (int i = 0; i < d; i++) begin
            for (int j = 0; j < d; j++) begin
                coef[j] = gf_mul(coef[j], root);
                if (j + 1 < d) begin
                    coef[j] = coef[j] ^ coef[j + 1];
                end
            end
            root = gf_mul(root, GF_ROOT);
        end
        return coef;
    endfunction

endpackage

`default_nettype wire

### rtl/core/rse_div.sv
// Remainder register, generator coefficient registers and the combinational division step.
`default_nettype none

module rse_div #(
    parameter int MAX_DEGREE = rse_pkg::PKG_MAX_DEGREE
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  rse_pkg::t_div_ctrl             i_ctrl,
    input  rse_pkg::t_byte                 i_msg_byte,
    output rse_pkg::t_byte [MAX_DEGREE-1:0] o_rem_next
);
    import rse_pkg::*;

    localparam int NUM_ROWS = 2 ** DEG_WIDTH;

    t_coef_row                 w_rows [NUM_ROWS];
    t_byte [MAX_DEGREE-1:0]    r_rem;
    t_byte [MAX_DEGREE-1:0]    n_rem;
    t_byte [MAX_DEGREE-1:0]    r_coef;
    t_byte [MAX_DEGREE-1:0]    n_coef;
    t_byte [MAX_DEGREE-1:0]    w_shift;
    t_byte [MAX_DEGREE-1:0]    w_new;
    t_byte                     w_factor;

    // One constant coefficient row for every value the degree register can hold.
    for (genvar g = 0; g < NUM_ROWS; g++) begin : g_row
        localparam t_coef_row ROW = gen_row(eff_degree(DEG_WIDTH'(g), MAX_DEGREE));
        assign w_rows[g] = ROW;
    end

    // Entries at and beyond the degree stay zero, so a full-width shift is exact.
    assign w_factor = i_msg_byte ^ r_rem[0];
    assign w_shift  = {8'h00, r_rem[MAX_DEGREE-1:1]};

    always_comb begin
        for (int i = 0; i < MAX_DEGREE; i++) begin
            w_new[i] = w_shift[i] ^ gf_mul(r_coef[i], w_factor);
        end
    end

    assign o_rem_next = w_new;
    assign n_coef     = w_rows[i_ctrl.degree][MAX_DEGREE-1:0];

    always_comb begin
        n_rem = r_rem;
        priority if (i_ctrl.clear) begin
            n_rem = '0;
        end else if (i_ctrl.accept) begin
            n_rem = i_ctrl.last ? '0 : w_new;
        end else begin
            n_rem = r_rem;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rem  <= '0;
            r_coef <= w_rows[DEGREE_RESET][MAX_DEGREE-1:0];
        end else begin
            r_rem <= n_rem;
            if (i_ctrl.clear) begin
                r_coef <= n_coef;
            end
        end
    end

    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctrl.clear |=> r_rem == '0)
        else $error("remainder not cleared after a degree write");

    a_last_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctrl.accept && i_ctrl.last) |=> r_rem == '0)
        else $error("remainder not cleared after the last message byte");

    a_coef_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctrl.clear |=> r_coef == $past(n_coef))
        else $error("coefficients not loaded after a degree write");

endmodule

`default_nettype wire

### rtl/core/reed_solomon_gf256_encoder.sv
// Top level of the systematic Reed-Solomon GF(256) parity encoder.
`default_nettype none

// Systematic Reed-Solomon parity encoder over GF(256), field polynomial 0x11D, generator
// roots 2^0 .. 2^(d-1). Message bytes enter on the msg channel, one per transaction, with
// i_msg_last on the final byte; the block takes one byte every clock cycle but for a last byte
// held off as below, and the whole division step (one XOR for the feedback factor, one GF
// multiply per coefficient lane and the shift) sits between the remainder register and itself.
// The cycle after the last byte is accepted, the d parity bytes appear on the parity channel,
// highest order first, one per transaction, with o_parity_last on the final one; d is
// ecc_degree with zero read as one and values above MAX_DEGREE saturated. The parity bytes
// drain from a separate output buffer, so bytes of the next message are taken while they go
// out; only a new last byte waits, until the previous run is down to its final parity byte
// being taken. ecc_degree sits at byte address 0 of the APB-style port (reset value 10);
// writing it loads the matching generator coefficients from a constant table in the same
// cycle and clears the remainder, and must only be done while idle.

module reed_solomon_gf256_encoder #(
    parameter int MAX_DEGREE = rse_pkg::PKG_MAX_DEGREE
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    // Message input
    input  wire                i_msg_valid,
    output logic               o_msg_ready,
    input  rse_pkg::t_byte     i_msg_byte,
    input  wire                i_msg_last,
    // Parity output
    output logic               o_parity_valid,
    input  wire                i_parity_ready,
    output rse_pkg::t_byte     o_parity_byte,
    output logic               o_parity_last,
    // Configuration
    input  wire                psel,
    input  wire                penable,
    input  wire                pwrite,
    input  wire  [2:0]         paddr,
    input  wire  [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import rse_pkg::*;

    localparam int CW = $clog2(MAX_DEGREE + 1);

    logic [DEG_WIDTH-1:0]   r_ecc;
    logic [CW-1:0]          r_eff_deg;
    logic [CW-1:0]          r_cnt;
    logic [CW-1:0]          n_cnt;
    t_byte [MAX_DEGREE-1:0] r_buf;
    t_byte [MAX_DEGREE-1:0] w_rem_next;
    t_div_ctrl              w_ctrl;
    logic                   w_cfg_wr;
    logic                   w_buf_free;
    logic                   w_in_acc;
    logic                   w_load;
    logic                   w_out_acc;

    // Configuration port: always ready, one register.
    assign pready   = 1'b1;
    assign prdata   = {{(32 - DEG_WIDTH){1'b0}}, r_ecc};
    assign w_cfg_wr = psel && penable && pwrite && pready &&
                      (paddr[2:2] == 1'(REG_ECC_DEGREE));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ecc     <= DEGREE_RESET;
            r_eff_deg <= CW'(eff_degree(DEGREE_RESET, MAX_DEGREE));
        end else if (w_cfg_wr) begin
            r_ecc     <= pwdata[DEG_WIDTH-1:0];
            r_eff_deg <= CW'(eff_degree(pwdata[DEG_WIDTH-1:0], MAX_DEGREE));
        end
    end

    // A last byte needs the output buffer to be free by the next edge; other bytes
    // only touch the remainder and are always taken.
    assign w_buf_free  = (r_cnt == '0) || ((r_cnt == CW'(1)) && i_parity_ready);
    assign o_msg_ready = w_buf_free || !i_msg_last;
    assign w_in_acc    = i_msg_valid && o_msg_ready;
    assign w_load      = w_in_acc && i_msg_last;

    assign w_ctrl.accept = w_in_acc;
    assign w_ctrl.last   = i_msg_last;
    assign w_ctrl.clear  = w_cfg_wr;
    assign w_ctrl.degree = pwdata[DEG_WIDTH-1:0];

    rse_div #(
        .MAX_DEGREE (MAX_DEGREE)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctrl     (w_ctrl),
        .i_msg_byte (i_msg_byte),
        .o_rem_next (w_rem_next)
    );

    // Output buffer: holds the finished remainder and shifts it out one byte per transaction.
    assign o_parity_valid = (r_cnt != '0);
    assign o_parity_byte  = r_buf[0];
    assign o_parity_last  = (r_cnt == CW'(1));
    assign w_out_acc      = o_parity_valid && i_parity_ready;

    always_comb begin
        n_cnt = r_cnt;
        priority if (w_load) begin
            n_cnt = r_eff_deg;
        end else if (w_out_acc) begin
            n_cnt = r_cnt - CW'(1);
        end else begin
            n_cnt = r_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        priority if (w_load) begin
            r_buf <= w_rem_next;
        end else if (w_out_acc) begin
            r_buf <= {8'h00, r_buf[MAX_DEGREE-1:1]};
        end else begin
            r_buf <= r_buf;
        end
    end

    a_run_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |=> (o_parity_valid && (r_cnt == $past(r_eff_deg))))
        else $error("parity run did not start with the full degree after a last byte");

    a_run_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_acc && o_parity_last && !w_load) |=> !o_parity_valid)
        else $error("parity output still valid after the final parity byte");

    a_plain_byte_taken: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_msg_last |-> o_msg_ready)
        else $error("a byte without the last mark was held off");

endmodule

`default_nettype wire
